// ===== src/aesc_pkg.sv =====
// Shared types, constants and AES byte functions for the AES-CTR stream cipher.
package aesc_pkg;

  localparam int BLOCK_BYTES_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int RK_ENTRIES      = 30;
  localparam int RK_AW           = 5;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_HI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_LO   = 3'd6;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_KLOAD,
    ST_ROUND,
    ST_DONE
  } core_state_t;

  // request / status between top and the block core
  typedef struct packed {
    logic start;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and optional MixColumns; byte 0 in bits 127:120
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = SBOX[s[127 - 8*(4*((c+i)%4)+i) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (mix) begin
        r[127 - 8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
        r[127 - 8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
        r[127 - 8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
        r[127 - 8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end else begin
        r[127 - 8*(4*c)   -: 8] = a0;
        r[127 - 8*(4*c+1) -: 8] = a1;
        r[127 - 8*(4*c+2) -: 8] = a2;
        r[127 - 8*(4*c+3) -: 8] = a3;
      end
    end
    round_fn = r;
  endfunction

endpackage

// ===== src/aesc_core.sv =====
// Iterative AES block core: key expansion into a round key RAM, then one round per step.
module aesc_core import aesc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  core_req_t    req,
  input  logic [1:0]   key_mode,
  input  logic [255:0] key,
  input  logic [127:0] ctr,
  output core_sts_t    sts,
  output logic [127:0] block
);

  // round key store: two words per entry
  logic [63:0] rk_mem [RK_ENTRIES];
  logic [63:0] rk_rd;
  logic [RK_AW-1:0] rd_addr;
  logic        wr_en;
  logic [RK_AW-1:0] wr_addr;
  logic [63:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_addr] <= wr_data;
    rk_rd <= rk_mem[rd_addr];
  end

  core_state_t state, state_next;
  logic [5:0]   widx;       // expansion word index
  logic [255:0] win;        // sliding window of last eight words, newest at bottom
  logic [1:0]   mode_q;     // key size held for the whole block
  logic [3:0]   nk, nr;
  logic [3:0]   rcnt;       // round being loaded
  logic         half;       // which half of the round key
  logic [63:0]  rk_hi;
  logic [127:0] st;
  logic [7:0]   rcon;
  logic [2:0]   kpos;       // widx mod nk
  logic [5:0]   total;

  assign nk = (mode_q == MODE_128) ? 4'd4 : (mode_q == MODE_192) ? 4'd6 : 4'd8;
  assign nr = nk + 4'd6;
  assign total = {nr, 2'b00} + 6'd4;

  // next expanded word
  logic [31:0] prev, back, tw, nw;
  always_comb begin
    prev = win[31:0];
    back = win[32*(nk-1) +: 32];
    tw = prev;
    if (kpos == 3'd0) tw = sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0};
    else if (nk == 4'd8 && kpos == 3'd4) tw = sub_word(prev);
    nw = back ^ tw;
  end

  logic [31:0] cur_word;
  always_comb begin
    cur_word = (widx < {2'b00, nk}) ? key[255 - 32*widx[2:0] -: 32] : nw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en = 1'b0;
    wr_addr = widx[5:1];
    wr_data = {win[31:0], cur_word};
    rd_addr = {rcnt, half};
    sts.busy = 1'b1;
    sts.done = 1'b0;
    case (state)
      ST_IDLE: begin
        sts.busy = 1'b0;
        if (req.start) state_next = ST_KEXP;
      end
      ST_KEXP: begin
        wr_en = widx[0];
        rd_addr = '0;
        if (widx == total - 6'd1) state_next = ST_KLOAD;
      end
      ST_KLOAD: state_next = ST_ROUND;
      ST_ROUND: begin
        // fetch the entry needed in the following cycle
        rd_addr = half ? {rcnt + 4'd1, 1'b0} : {rcnt, 1'b1};
        if (rcnt == nr && half) state_next = ST_DONE;
      end
      ST_DONE: begin
        sts.busy = 1'b0;
        sts.done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        widx <= '0;
        kpos <= '0;
        rcon <= 8'h01;
        st <= ctr;
        mode_q <= key_mode;
      end
      ST_KEXP: begin
        win <= {win[223:0], cur_word};
        widx <= widx + 6'd1;
        if (widx >= {2'b00, nk}) begin
          if (kpos == nk[2:0] - 3'd1 || (nk == 4'd8 && kpos == 3'd7)) begin
            kpos <= '0;
          end else begin
            kpos <= kpos + 3'd1;
          end
          if (kpos == 3'd0) rcon <= xtime(rcon);
        end else if (widx == {2'b00, nk} - 6'd1) begin
          kpos <= '0;
        end
        rcnt <= '0;
        half <= 1'b1;
      end
      ST_KLOAD: begin
        rk_hi <= rk_rd;     // round 0 first half
      end
      ST_ROUND: begin
        // alternate: latch upper half, then apply the full round key
        if (!half) begin
          half <= 1'b1;
          rk_hi <= rk_rd;
        end else begin
          if (rcnt == '0) st <= st ^ {rk_hi, rk_rd};
          else st <= round_fn(st, rcnt != nr) ^ {rk_hi, rk_rd};
          rcnt <= rcnt + 4'd1;
          half <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign block = st;

endmodule

// ===== src/aes_ctr_stream_cipher_unit.sv =====
// AES-CTR stream cipher top level: config registers, counter, byte buffer and output stage.
// One byte per cycle while a keystream block is available and the output is not stalled.
// Block time is set by the key expansion and the fetch of each round key in two halves
// through the single read port of the round key RAM. The next block is built while the
// current one is consumed, so streaming stalls only when bytes arrive faster than the
// core builds blocks. A key write discards any block not yet started and rebuilds it, a
// counter write discards every buffered block, and input is held off in the cycle of any
// register write.
module aes_ctr_stream_cipher_unit import aesc_pkg::*; #(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte
);

  localparam int OFF_W = $clog2(BLOCK_BYTES);

  logic [1:0]   key_mode;
  logic [255:0] key;
  logic [63:0]  counter_high, counter_low;
  logic [127:0] rctr;
  logic [OFF_W-1:0] offset;
  logic [127:0] ks;         // current block
  logic         ks_valid;
  logic [127:0] nxt;        // prefetched block
  logic         nxt_valid;
  logic         pending;    // core working
  logic         stale;      // block in the core uses old settings
  core_req_t    req;
  core_sts_t    sts;
  logic [127:0] blk;

  aesc_core u_core (
    .clk, .rst, .req, .key_mode, .key, .ctr(rctr), .sts, .block(blk)
  );

  logic ctr_wr, key_wr, cfg_hit, store, drop_ks, in_xfer, last;
  assign ctr_wr = cfg_we && (cfg_index == REG_CTR_HI || cfg_index == REG_CTR_LO);
  assign key_wr = cfg_we && (cfg_index == REG_KEY_MODE || cfg_index == REG_KEY_W0 ||
                             cfg_index == REG_KEY_W1 || cfg_index == REG_KEY_W2 ||
                             cfg_index == REG_KEY_W3);
  assign cfg_hit = ctr_wr || key_wr;
  assign in_ready = ks_valid && (!out_valid || out_ready) && !cfg_we;
  assign in_xfer = in_valid && in_ready;
  assign last = (offset == OFF_W'(BLOCK_BYTES - 1));
  assign store = sts.done && !stale && !cfg_hit;
  assign drop_ks = ks_valid && (offset == '0);
  assign req.start = !pending && !nxt_valid && !sts.busy && !cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= '0; key <= '0; counter_high <= '0; counter_low <= '0;
      rctr <= '0; offset <= '0; ks_valid <= 1'b0; nxt_valid <= 1'b0;
      pending <= 1'b0; stale <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (req.start) pending <= 1'b1;
      if (sts.done) begin
        pending <= 1'b0;
        stale <= 1'b0;
      end else if (cfg_hit && pending) begin
        stale <= 1'b1;
      end
      if (store) begin
        rctr <= rctr + 128'd1;
        if (!ks_valid || (in_xfer && last)) begin
          ks <= blk; ks_valid <= 1'b1;
        end else begin
          nxt <= blk; nxt_valid <= 1'b1;
        end
      end
      if (in_xfer) begin
        offset <= last ? '0 : offset + OFF_W'(1);
        if (last && !store) begin
          ks <= nxt; ks_valid <= nxt_valid; nxt_valid <= 1'b0;
        end
      end
      if (in_xfer) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_MODE: key_mode <= cfg_data[1:0];
          REG_KEY_W0:   key[255:192] <= cfg_data;
          REG_KEY_W1:   key[191:128] <= cfg_data;
          REG_KEY_W2:   key[127:64]  <= cfg_data;
          REG_KEY_W3:   key[63:0]    <= cfg_data;
          REG_CTR_HI: begin
            counter_high <= cfg_data;
            rctr <= {cfg_data, counter_low};
          end
          REG_CTR_LO: begin
            counter_low <= cfg_data;
            rctr <= {counter_high, cfg_data};
          end
          default: ;
        endcase
      end
      // blocks not yet started were built with the old key; step the counter back
      if (key_wr) begin
        rctr <= rctr - 128'(nxt_valid) - 128'(drop_ks);
        nxt_valid <= 1'b0;
        if (drop_ks) ks_valid <= 1'b0;
      end
      // counter reload drops any block built from the old counter
      if (ctr_wr) begin
        offset <= '0; ks_valid <= 1'b0; nxt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) out_byte <= in_byte ^ ks[127 - 8*offset -: 8];
  end

endmodule
